// File: sv/gnpl_pkg.sv
// Shared types, request codes and constants for the gated nearest pose lookup.
// Used by gnpl_ctrl, gnpl_datapath and gated_nearest_pose_lookup_unit.
package gnpl_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 1024;

    localparam int DIST_LIMIT_W  = 31;
    localparam int HEAD_LIMIT_W  = 15;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int POS_W         = 32;
    localparam int ANGLE_W       = 16;
    localparam int LIM_SQ_W      = 2 * DIST_LIMIT_W;
    localparam int SQ_W          = 2 * POS_W;
    localparam int SUM_W         = SQ_W + 1;

    localparam logic [DIST_LIMIT_W-1:0] DIST_LIMIT_RESET = DIST_LIMIT_W'(1000);
    localparam logic [HEAD_LIMIT_W-1:0] HEAD_LIMIT_RESET = HEAD_LIMIT_W'(410);

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_LIMIT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADING_LIMIT  = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic signed [ANGLE_W-1:0]  heading;
        logic signed [ANGLE_W-1:0]  entry_pitch;
    } req_t;

    typedef struct packed {
        logic                       found;
        logic signed [ANGLE_W-1:0]  pitch_value;
        logic                       overflowed;
    } rsp_t;

    typedef struct packed {
        logic signed [POS_W-1:0]    x;
        logic signed [POS_W-1:0]    y;
        logic signed [ANGLE_W-1:0]  heading;
        logic signed [ANGLE_W-1:0]  pitch;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic scan_start;
        logic scan_issue;
        logic load_rsp;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// File: sv/gnpl_ctrl.sv
// Controller state machine for the gated nearest pose lookup.
// Depends on gnpl_pkg; drives commands into gnpl_datapath from its status.
module gnpl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [1:0]      req_type,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    input  gnpl_pkg::status_t status,
    output gnpl_pkg::cmd_t  cmd
);
    import gnpl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_type == REQ_QUERY)
                begin
                    state_next = status.count_zero ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall      = 1'b0;
                cmd.clear      = req_valid && req_type == REQ_CLEAR;
                cmd.append     = req_valid && req_type == REQ_APPEND;
                cmd.scan_start = req_valid && req_type == REQ_QUERY;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_FINISH:
            begin
                cmd.load_rsp = rsp_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        rsp_valid_next = cmd.load_rsp || (rsp_valid_reg && rsp_stall);
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// File: sv/gnpl_datapath.sv
// Datapath for the gated nearest pose lookup: pose memory, limits, scan pipeline.
// Depends on gnpl_pkg; steered by commands from gnpl_ctrl.
module gnpl_datapath #(
    parameter int TABLE_DEPTH = gnpl_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gnpl_pkg::req_t                   req,
    input  logic                             cfg_write,
    input  logic [gnpl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gnpl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  gnpl_pkg::cmd_t                   cmd,
    output gnpl_pkg::status_t                status,
    output gnpl_pkg::rsp_t                   rsp
);
    import gnpl_pkg::*;

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

    entry_t mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]      count_reg;
    logic                    overflow_reg;
    logic [DIST_LIMIT_W-1:0] dist_limit_reg;
    logic [HEAD_LIMIT_W-1:0] head_limit_reg;
    logic [LIM_SQ_W-1:0]     lim_sq_reg;
    logic [ADDR_W-1:0]       scan_addr_reg;
    logic                    full;

    logic signed [POS_W-1:0]   qx_reg;
    logic signed [POS_W-1:0]   qy_reg;
    logic signed [ANGLE_W-1:0] qh_reg;

    entry_t                    rd_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      v4_reg;

    logic signed [POS_W:0]     dx_full;
    logic signed [POS_W:0]     dy_full;
    logic signed [ANGLE_W:0]   dh_full;
    logic [POS_W-1:0]          dx_next;
    logic [POS_W-1:0]          dy_next;
    logic [ANGLE_W-1:0]        dh_next;

    logic [POS_W-1:0]          dx_reg;
    logic [POS_W-1:0]          dy_reg;
    logic [ANGLE_W-1:0]        dh_reg;
    logic signed [ANGLE_W-1:0] pitch2_reg;

    logic [SQ_W-1:0]           sqx_reg;
    logic [SQ_W-1:0]           sqy_reg;
    logic                      hok3_reg;
    logic signed [ANGLE_W-1:0] pitch3_reg;

    logic [SUM_W-1:0]          sum_reg;
    logic                      hok4_reg;
    logic signed [ANGLE_W-1:0] pitch4_reg;

    logic                      found_reg;
    logic [LIM_SQ_W-1:0]       best_reg;
    logic signed [ANGLE_W-1:0] best_pitch_reg;
    logic                      qualify;

    rsp_t                      rsp_reg;

    assign full = count_reg == COUNT_W'(TABLE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            dist_limit_reg <= DIST_LIMIT_RESET;
            head_limit_reg <= HEAD_LIMIT_RESET;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_DISTANCE_LIMIT)
            begin
                dist_limit_reg <= cfg_data[DIST_LIMIT_W-1:0];
            end
            if (cfg_write && cfg_index == CFG_HEADING_LIMIT)
            begin
                head_limit_reg <= cfg_data[HEAD_LIMIT_W-1:0];
            end
            if (cmd.clear)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else if (cmd.append)
            begin
                if (full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= '{x: req.pos_x, y: req.pos_y,
                                            heading: req.heading,
                                            pitch: req.entry_pitch};
        end
        if (cmd.scan_issue)
        begin
            rd_reg <= mem[scan_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (qualify)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        dx_full = {qx_reg[POS_W-1], qx_reg} - {rd_reg.x[POS_W-1], rd_reg.x};
        dy_full = {qy_reg[POS_W-1], qy_reg} - {rd_reg.y[POS_W-1], rd_reg.y};
        dh_full = {qh_reg[ANGLE_W-1], qh_reg}
                - {rd_reg.heading[ANGLE_W-1], rd_reg.heading};
        dx_next = dx_full[POS_W] ? POS_W'(-dx_full) : dx_full[POS_W-1:0];
        dy_next = dy_full[POS_W] ? POS_W'(-dy_full) : dy_full[POS_W-1:0];
        dh_next = dh_full[ANGLE_W] ? ANGLE_W'(-dh_full) : dh_full[ANGLE_W-1:0];
    end

    assign qualify = v4_reg && hok4_reg
                  && sum_reg < {{(SUM_W - LIM_SQ_W){1'b0}}, lim_sq_reg}
                  && (!found_reg || sum_reg < {{(SUM_W - LIM_SQ_W){1'b0}}, best_reg});

    always_ff @(posedge clk)
    begin
        lim_sq_reg <= LIM_SQ_W'(dist_limit_reg) * LIM_SQ_W'(dist_limit_reg);
        if (cmd.scan_start)
        begin
            qx_reg         <= req.pos_x;
            qy_reg         <= req.pos_y;
            qh_reg         <= req.heading;
            best_pitch_reg <= '0;
        end
        else if (qualify)
        begin
            best_reg       <= sum_reg[LIM_SQ_W-1:0];
            best_pitch_reg <= pitch4_reg;
        end
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dh_reg     <= dh_next;
        pitch2_reg <= rd_reg.pitch;
        sqx_reg    <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg    <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        hok3_reg   <= dh_reg < {{(ANGLE_W - HEAD_LIMIT_W){1'b0}}, head_limit_reg};
        pitch3_reg <= pitch2_reg;
        sum_reg    <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        hok4_reg   <= hok3_reg;
        pitch4_reg <= pitch3_reg;
        if (cmd.load_rsp)
        begin
            rsp_reg <= '{found: found_reg, pitch_value: best_pitch_reg,
                         overflowed: overflow_reg};
        end
    end

    assign status.count_zero = count_reg == '0;
    assign status.scan_last  = COUNT_W'(scan_addr_reg) + 1'b1 == count_reg;
    assign status.pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign rsp               = rsp_reg;

endmodule

// File: sv/gated_nearest_pose_lookup_unit.sv
// Gated nearest pose lookup: top level joining gnpl_ctrl and gnpl_datapath.
// Clear and append transactions yield no result.
// A query scans the N stored poses one a cycle, lets the scan pipeline drain,
// then loads its result once the result side is free.
// For an empty table the scan is skipped; one query at a time.
// Reset (rst_n, asynchronous) empties the table, clears overflow, restores limits.
module gated_nearest_pose_lookup_unit #(
    parameter int TABLE_DEPTH = gnpl_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  gnpl_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output gnpl_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gnpl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gnpl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gnpl_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    gnpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gnpl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rsp |-> !(rsp_valid && rsp_stall))
        else $error("pending result overwritten");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.req_type == REQ_QUERY |=> req_stall)
        else $error("query accepted without blocking the request side");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> !cmd.append && !cmd.clear)
        else $error("table modified during a scan");

    a_empty_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.pitch_value == '0)
        else $error("pitch reported without a match");
`endif

endmodule
